[rtl/rounded_multiply_divide_assert.svh]
// Assertion macros for the rounded multiply-divide block
`ifndef ROUNDED_MULTIPLY_DIVIDE_ASSERT_SVH
`define ROUNDED_MULTIPLY_DIVIDE_ASSERT_SVH

// Check that a condition implies a consequence on the same edge
`define RMD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence on the next edge
`define RMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rmd_pkg.sv]
// Shared types and constants for the rounded multiply-divide block
`default_nettype none
package rmd_pkg;
  localparam int OPERAND_WIDTH_DEF = 64;
  localparam int NARROW_WIDTH      = 32;
  localparam int FIELD_WIDTH       = 64;

  // Control that travels alongside each item through the pipeline
  typedef struct packed {
    logic vld;
    logic pneg;
    logic dneg;
    logic zdiv;
    logic wide;
  } rmd_side_t;
endpackage
`default_nettype wire

[rtl/rounded_multiply_divide.sv]
// Rounded multiply-divide: top level with the division cell chain
// Computes numerator * value / denominator rounded to nearest, in a 32-bit
// or OPERAND_WIDTH-bit form chosen by the wide_mode register (reset 1).
// One item is accepted per cycle; each item passes through three front stages
// for operand conditioning, the split multiply and the rounding offset, one
// division cell per dividend bit, and the output register. A stalled output
// holds the whole pipeline. A zero denominator or an out-of-range quotient gives
// a zero quotient with its flag set.
`default_nettype none
module rounded_multiply_divide
  import rmd_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_wide_mode,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [FIELD_WIDTH-1:0] in_scale_numerator,
  input  wire logic signed [FIELD_WIDTH-1:0] in_scaled_value,
  input  wire logic signed [FIELD_WIDTH-1:0] in_scale_denominator,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [FIELD_WIDTH-1:0]      out_rounded_quotient,
  output logic                               out_overflow_flag,
  output logic                               out_zero_divisor_flag
);
  // Clamp the operand width into the supported range
  localparam int OW = (OPERAND_WIDTH < NARROW_WIDTH) ? NARROW_WIDTH :
                      (OPERAND_WIDTH > FIELD_WIDTH) ? FIELD_WIDTH : OPERAND_WIDTH;
  localparam int NC = 2 * OW;

  logic wide_r;
  logic en;
  logic out_valid_r;
  logic signed [FIELD_WIDTH-1:0] quo_r;
  logic ovf_r, zdv_r;

  rmd_side_t       side_c [0:NC];
  logic [2*OW-1:0] num_c  [0:NC];
  logic [OW-1:0]   rem_c  [0:NC];
  logic [OW-1:0]   md_c   [0:NC];
  logic [OW-1:0]   q_c    [0:NC];
  logic            stk_c  [0:NC];

  logic [OW-1:0] lim, qv, res;
  logic qnz, qneg, ovf;
  logic signed [FIELD_WIDTH-1:0] quo_nxt;
  logic ovf_nxt, zdv_nxt;

  // Hold the mode register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      wide_r <= cfg_wide_mode;
    end
  end

  // Advance the pipeline unless a finished item waits
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  rmd_front #(.OW(OW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .wide   (wide_r),
    .num_in (in_scale_numerator),
    .val_in (in_scaled_value),
    .den_in (in_scale_denominator),
    .side_o (side_c[0]),
    .prod_o (num_c[0]),
    .md_o   (md_c[0])
  );

  assign rem_c[0] = '0;
  assign q_c[0]   = '0;
  assign stk_c[0] = 1'b0;

  // Chain of division cells, most significant dividend bit first
  for (genvar k = 0; k < NC; k++) begin : g_cell
    rmd_div_cell #(.OW(OW), .UPPER(k < OW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .side_i (side_c[k]),
      .num_i  (num_c[k]),
      .rem_i  (rem_c[k]),
      .md_i   (md_c[k]),
      .q_i    (q_c[k]),
      .stk_i  (stk_c[k]),
      .side_o (side_c[k+1]),
      .num_o  (num_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .md_o   (md_c[k+1]),
      .q_o    (q_c[k+1]),
      .stk_o  (stk_c[k+1])
    );
  end

  // Apply sign, range check and error handling
  always_comb begin
    qv   = q_c[NC];
    qnz  = stk_c[NC] || (qv != '0);
    qneg = (side_c[NC].pneg ^ side_c[NC].dneg) && qnz;
    lim  = side_c[NC].wide ? (OW'(1) << (OW - 1)) : (OW'(1) << (NARROW_WIDTH - 1));
    if (!qneg) begin
      lim = lim - OW'(1);
    end
    ovf = stk_c[NC] || (qv > lim);
    res = qneg ? (~qv + OW'(1)) : qv;
    quo_nxt = '0;
    ovf_nxt = 1'b0;
    zdv_nxt = 1'b0;
    if (side_c[NC].zdiv) begin
      zdv_nxt = 1'b1;
    end else if (ovf) begin
      ovf_nxt = 1'b1;
    end else begin
      quo_nxt = FIELD_WIDTH'($signed(res));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_c[NC].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      ovf_r <= ovf_nxt;
      zdv_r <= zdv_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_rounded_quotient  = quo_r;
  assign out_overflow_flag     = ovf_r;
  assign out_zero_divisor_flag = zdv_r;

`include "rounded_multiply_divide_assert.svh"

  `RMD_ASSERT_IMPLY(a_flags_excl, out_valid, !(out_overflow_flag && out_zero_divisor_flag), "both error flags set")
  `RMD_ASSERT_IMPLY(a_err_zero, out_valid && (out_overflow_flag || out_zero_divisor_flag), out_rounded_quotient == '0, "error item carries nonzero quotient")
  `RMD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_rounded_quotient), "stalled item changed")

endmodule
`default_nettype wire

[rtl/rmd_front.sv]
// Operand conditioning, split multiply and rounding offset stages
`default_nettype none
module rmd_front
  import rmd_pkg::*;
#(
  parameter int OW = OPERAND_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire logic                          wide,
  input  wire logic signed [FIELD_WIDTH-1:0] num_in,
  input  wire logic signed [FIELD_WIDTH-1:0] val_in,
  input  wire logic signed [FIELD_WIDTH-1:0] den_in,
  output rmd_side_t                          side_o,
  output logic [2*OW-1:0]                    prod_o,
  output logic [OW-1:0]                      md_o
);
  localparam int H = (OW + 1) / 2;
  localparam int L = OW - H;

  logic [OW-1:0] n_x, v_x, d_x;
  logic [OW-1:0] mn_nxt, mv_nxt, md_nxt;
  rmd_side_t     s1_nxt;
  logic [OW-1:0] mn_r, mv_r, md1_r;
  rmd_side_t     s1_r;
  logic [2*H-1:0] pp00_r, pp01_r, pp10_r;
  logic [2*L-1:0] pp11_r;
  logic [OW-1:0]  md2_r;
  rmd_side_t      s2_r;
  logic [2*OW-1:0] sum_nxt;
  logic [2*OW-1:0] prod_r;
  logic [OW-1:0]   md3_r;
  rmd_side_t       s3_r;

  // Sign-extend operands to the selected width and take magnitudes
  always_comb begin
    n_x = wide ? num_in[OW-1:0] : OW'($signed(num_in[NARROW_WIDTH-1:0]));
    v_x = wide ? val_in[OW-1:0] : OW'($signed(val_in[NARROW_WIDTH-1:0]));
    d_x = wide ? den_in[OW-1:0] : OW'($signed(den_in[NARROW_WIDTH-1:0]));
    mn_nxt = n_x[OW-1] ? (~n_x + OW'(1)) : n_x;
    mv_nxt = v_x[OW-1] ? (~v_x + OW'(1)) : v_x;
    md_nxt = d_x[OW-1] ? (~d_x + OW'(1)) : d_x;
    s1_nxt.vld  = in_vld;
    s1_nxt.pneg = (n_x[OW-1] ^ v_x[OW-1]) && (n_x != '0) && (v_x != '0);
    s1_nxt.dneg = d_x[OW-1];
    s1_nxt.zdiv = (d_x == '0);
    s1_nxt.wide = wide;
  end

  // Add the four partial products into the full product
  always_comb begin
    sum_nxt = (2*OW)'(pp00_r)
            + ((2*OW)'(pp01_r) << H)
            + ((2*OW)'(pp10_r) << H)
            + ((2*OW)'(pp11_r) << (2*H));
  end

  // Advance the three front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      s3_r.vld <= 1'b0;
    end else if (en) begin
      mn_r   <= mn_nxt;
      mv_r   <= mv_nxt;
      md1_r  <= md_nxt;
      s1_r   <= s1_nxt;
      pp00_r <= (2*H)'(mn_r[H-1:0]) * (2*H)'(mv_r[H-1:0]);
      pp01_r <= (2*H)'(mn_r[H-1:0]) * (2*H)'(mv_r[OW-1:H]);
      pp10_r <= (2*H)'(mn_r[OW-1:H]) * (2*H)'(mv_r[H-1:0]);
      pp11_r <= (2*L)'(mn_r[OW-1:H]) * (2*L)'(mv_r[OW-1:H]);
      md2_r  <= md1_r;
      s2_r   <= s1_r;
      prod_r <= sum_nxt + (2*OW)'(md2_r >> 1);
      md3_r  <= md2_r;
      s3_r   <= s2_r;
    end
  end

  assign side_o = s3_r;
  assign prod_o = prod_r;
  assign md_o   = md3_r;
endmodule
`default_nettype wire

[rtl/rmd_div_cell.sv]
// One restoring-division cell: resolves one quotient bit per item, or in an upper cell folds it into the sticky bit
`default_nettype none
module rmd_div_cell
  import rmd_pkg::*;
#(
  parameter int OW    = OPERAND_WIDTH_DEF,
  parameter bit UPPER = 1'b0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire rmd_side_t        side_i,
  input  wire logic [2*OW-1:0]  num_i,
  input  wire logic [OW-1:0]    rem_i,
  input  wire logic [OW-1:0]    md_i,
  input  wire logic [OW-1:0]    q_i,
  input  wire logic             stk_i,
  output rmd_side_t             side_o,
  output logic [2*OW-1:0]       num_o,
  output logic [OW-1:0]         rem_o,
  output logic [OW-1:0]         md_o,
  output logic [OW-1:0]         q_o,
  output logic                  stk_o
);
  logic [OW:0]   rem_s;
  logic          ge;
  logic [OW:0]   diff;
  logic [OW-1:0] rem_nxt, q_nxt;
  logic          stk_nxt;
  rmd_side_t     side_r;
  logic [2*OW-1:0] num_r;
  logic [OW-1:0] rem_r, md_r, q_r;
  logic          stk_r;

  // Shift in the next dividend bit, compare and subtract
  always_comb begin
    rem_s   = {rem_i, num_i[2*OW-1]};
    diff    = rem_s - {1'b0, md_i};
    ge      = (rem_s >= {1'b0, md_i});
    rem_nxt = ge ? diff[OW-1:0] : rem_s[OW-1:0];
    if (UPPER) begin
      stk_nxt = stk_i | ge;
      q_nxt   = q_i;
    end else begin
      stk_nxt = stk_i;
      q_nxt   = {q_i[OW-2:0], ge};
    end
  end

  // Hand the item to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (en) begin
      side_r <= side_i;
      num_r  <= {num_i[2*OW-2:0], 1'b0};
      rem_r  <= rem_nxt;
      md_r   <= md_i;
      q_r    <= q_nxt;
      stk_r  <= stk_nxt;
    end
  end

  assign side_o = side_r;
  assign num_o  = num_r;
  assign rem_o  = rem_r;
  assign md_o   = md_r;
  assign q_o    = q_r;
  assign stk_o  = stk_r;
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for rounded_multiply_divide: driver, monitor and rounding predictor
`timescale 1ns / 1ps
module tb_top
  import rmd_pkg::*;
();

  localparam int RST_CYCLES  = 8;
  localparam int DRAIN_WAIT  = 200;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [63:0] num;
    logic [63:0] val;
    logic [63:0] den;
  } scaling_t;

  typedef struct {
    logic [63:0] quot;
    logic        ovf;
    logic        zdiv;
  } quotient_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_wide_mode = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [FIELD_WIDTH-1:0] in_scale_numerator = '0;
  logic signed [FIELD_WIDTH-1:0] in_scaled_value = '0;
  logic signed [FIELD_WIDTH-1:0] in_scale_denominator = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FIELD_WIDTH-1:0] out_rounded_quotient;
  logic out_overflow_flag;
  logic out_zero_divisor_flag;

  scaling_t  pending_scalings[$];
  quotient_t expected_quotients[$];
  logic      wide_now = 1'b1;
  logic      in_taken = 1'b0;
  int        err_count = 0;
  int        cycles = 0;

  rounded_multiply_divide dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_wide_mode        (cfg_wide_mode),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_scale_numerator   (in_scale_numerator),
    .in_scaled_value      (in_scaled_value),
    .in_scale_denominator (in_scale_denominator),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_rounded_quotient (out_rounded_quotient),
    .out_overflow_flag    (out_overflow_flag),
    .out_zero_divisor_flag(out_zero_divisor_flag)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Sign-extend from the active width, take magnitudes, round, divide and range-check
  function automatic quotient_t predict_quotient(scaling_t s, logic wide);
    quotient_t   r;
    logic [63:0] n, v, d, mn, mv, md;
    logic [127:0] prod, q, limit;
    logic        pneg, qneg;
    n = wide ? s.num : {{32{s.num[31]}}, s.num[31:0]};
    v = wide ? s.val : {{32{s.val[31]}}, s.val[31:0]};
    d = wide ? s.den : {{32{s.den[31]}}, s.den[31:0]};
    mn = n[63] ? -n : n;
    mv = v[63] ? -v : v;
    md = d[63] ? -d : d;
    r = '{quot: 64'd0, ovf: 1'b0, zdiv: 1'b0};
    if (md == 64'd0) begin
      r.zdiv = 1'b1;
      return r;
    end
    prod = {64'd0, mn} * {64'd0, mv};
    pneg = (n[63] != v[63]) && (prod != 128'd0);
    q = (prod + {65'd0, md[63:1]}) / {64'd0, md};
    qneg = (pneg != d[63]) && (q != 128'd0);
    limit = 128'd1 << (wide ? 63 : 31);
    if (!qneg) limit = limit - 128'd1;
    if (q > limit) begin
      r.ovf = 1'b1;
      return r;
    end
    r.quot = qneg ? -q[63:0] : q[63:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    err_count++;
  endtask

  // Pick an operand: extremes, small values, 32-bit corner words with junk above
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 11))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'd0;
      3: return 64'd1;
      4: return '1;
      5: return {$urandom, 32'h8000_0000};
      6: return {$urandom, 32'h7fff_ffff};
      7: return 64'($signed($urandom_range(0, 40)) - 20);
      8: return {$urandom, $urandom_range(0, 9)};
      9: return {{32{1'b0}}, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_random(int count);
    scaling_t s;
    repeat (count) begin
      s.num = pick_operand();
      s.val = pick_operand();
      s.den = pick_operand();
      if ($urandom_range(0, 19) == 0) s.den = {$urandom, 32'd0};
      pending_scalings.push_back(s);
    end
  endtask

  task automatic queue_directed();
    pending_scalings.push_back('{64'h8000_0000_0000_0000, '1, 64'd1});
    pending_scalings.push_back('{64'hffff_ffff_8000_0000, '1, 64'd1});
    pending_scalings.push_back('{64'd5, 64'd7, 64'd0});
    pending_scalings.push_back('{64'd5, 64'd7, 64'h1234_5678_0000_0000});
    pending_scalings.push_back('{64'd3, 64'd1, 64'd2});
    pending_scalings.push_back('{-64'sd3, 64'd1, 64'd2});
    pending_scalings.push_back('{64'd1, 64'd1, -64'sd2});
    pending_scalings.push_back('{64'd0, 64'd9, -64'sd7});
    pending_scalings.push_back('{64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
                                 64'h7fff_ffff_ffff_ffff});
    pending_scalings.push_back('{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                                 64'h8000_0000_0000_0000});
    pending_scalings.push_back('{64'h8000_0000_0000_0000, 64'd1, '1});
    pending_scalings.push_back('{64'h7fff_ffff_ffff_ffff, 64'd2, 64'd1});
    pending_scalings.push_back('{64'h0000_0000_7fff_ffff, 64'd2, 64'd1});
    pending_scalings.push_back('{64'hdead_beef_0000_0007, 64'hffff_0000_0000_0003,
                                 64'h0123_4567_ffff_fffe});
    pending_scalings.push_back('{-64'sd7, -64'sd3, 64'd4});
    pending_scalings.push_back('{64'd10, 64'd1, 64'd4});
  endtask

  task automatic write_mode(logic wide);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_wide_mode = wide;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold until the driver is empty and every expected quotient has come
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_scalings.size() != 0 || in_valid || expected_quotients.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    logic     drive;
    scaling_t s;
    drive = in_valid && !in_taken;
    in_taken = 1'b0;
    if (rst_n && !drive) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_scalings.size() != 0) begin
        s = pending_scalings.pop_front();
        in_scale_numerator <= s.num;
        in_scaled_value <= s.val;
        in_scale_denominator <= s.den;
        drive = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_valid <= drive;
  end

  // Receiver: stall pattern shifts between open, patchy and long stalls
  int ready_phase = 0;
  always @(negedge clk) begin
    ready_phase++;
    case ((ready_phase / 300) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      default: out_ready <= ((ready_phase % 23) > 15);
    endcase
  end

  // Monitor: predict on accepted items, check accepted results, track the mode
  always @(posedge clk) begin
    quotient_t want;
    scaling_t  s;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) wide_now = cfg_wide_mode;
      if (in_valid && in_ready) begin
        s = '{in_scale_numerator, in_scaled_value, in_scale_denominator};
        expected_quotients.push_back(predict_quotient(s, wide_now));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_quotients.size() == 0) begin
          report_mismatch("unexpected result", out_rounded_quotient, 64'd0);
        end else begin
          want = expected_quotients.pop_front();
          if (out_rounded_quotient !== want.quot)
            report_mismatch("rounded_quotient", out_rounded_quotient, want.quot);
          if (out_overflow_flag !== want.ovf)
            report_mismatch("overflow_flag", 64'(out_overflow_flag), 64'(want.ovf));
          if (out_zero_divisor_flag !== want.zdiv)
            report_mismatch("zero_divisor_flag", 64'(out_zero_divisor_flag),
                            64'(want.zdiv));
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // Reset mode is wide
    queue_directed();
    queue_random(100);
    wait_idle();
    queue_random(60);
    wait_idle();
    write_mode(1'b0);
    queue_directed();
    queue_random(160);
    wait_idle();
    write_mode(1'b1);
    queue_random(140);
    wait_idle();
    write_mode(1'b0);
    queue_random(110);
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
